// ===== design/dlsd_pkg.sv =====
// ----------------------------------------------------------------------------
// dlsd_pkg
// shared constants, control codes and types for the dual lane stream digest
// ----------------------------------------------------------------------------
package dlsd_pkg;

	// hash constants
	localparam logic [63:0] OFFSET_ONE = 64'hCBF29CE484222325;
	localparam logic [63:0] OFFSET_TWO = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] FNV_PRIME  = 64'h00000100000001B3;
	localparam logic [63:0] GOLDEN     = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] FMIX_K1    = 64'hFF51AFD7ED558CCD;
	localparam logic [63:0] FMIX_K2    = 64'hC4CEB9FE1A85EC53;
	localparam logic [63:0] LEN_TWEAK  = 64'h00000005DEECE66D;

	// accumulator operations
	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	// accumulator operand sources
	localparam logic [1:0] SRC_EXT     = 2'd0;
	localparam logic [1:0] SRC_PROD    = 2'd1;
	localparam logic [1:0] SRC_PROD_HI = 2'd2;

	// partial product selects
	localparam logic [1:0] PART_NONE = 2'd0;
	localparam logic [1:0] PART_LL   = 2'd1;
	localparam logic [1:0] PART_HL   = 2'd2;
	localparam logic [1:0] PART_LH   = 2'd3;

	// multiplier constant selects
	localparam logic [1:0] BSEL_PRIME = 2'd0;
	localparam logic [1:0] BSEL_K1    = 2'd1;
	localparam logic [1:0] BSEL_K2    = 2'd2;

	typedef struct packed {
		logic [1:0] acc_op;
		logic [1:0] src;
		logic [1:0] part;
		logic [1:0] bsel;
	} mac_ctl_t;

	function automatic logic [63:0] mul_const(input logic [1:0] bsel);
		logic [63:0] k;
		unique case (bsel)
			BSEL_PRIME: k = FNV_PRIME;
			BSEL_K1:    k = FMIX_K1;
			BSEL_K2:    k = FMIX_K2;
			default:    k = FNV_PRIME;
		endcase
		return k;
	endfunction

endpackage

// ===== design/dlsd_mac.sv =====
// ----------------------------------------------------------------------------
// dlsd_mac
// shared 32x32 multiplier with a 64-bit add/accumulate register
// ----------------------------------------------------------------------------
module dlsd_mac (
	input  logic                clk,
	input  dlsd_pkg::mac_ctl_t  ctl,
	input  logic [63:0]         mul_a,
	input  logic [63:0]         ext,
	output logic [63:0]         acc
);

	logic [63:0] b_const;
	logic [31:0] op_x;
	logic [31:0] op_y;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [63:0] operand;

	assign b_const = dlsd_pkg::mul_const(ctl.bsel);

	// partial product operand select
	always_comb begin
		unique case (ctl.part)
			dlsd_pkg::PART_HL: begin
				op_x = mul_a[63:32];
				op_y = b_const[31:0];
			end
			dlsd_pkg::PART_LH: begin
				op_x = mul_a[31:0];
				op_y = b_const[63:32];
			end
			default: begin
				op_x = mul_a[31:0];
				op_y = b_const[31:0];
			end
		endcase
	end

	// accumulator operand select
	always_comb begin
		unique case (ctl.src)
			dlsd_pkg::SRC_PROD:    operand = prod_q;
			dlsd_pkg::SRC_PROD_HI: operand = {prod_q[31:0], 32'd0};
			default:               operand = ext;
		endcase
	end

	// product register
	always_ff @(posedge clk) begin
		if (ctl.part != dlsd_pkg::PART_NONE) begin
			prod_q <= op_x * op_y;
		end
	end

	// accumulator
	always_ff @(posedge clk) begin
		unique case (ctl.acc_op)
			dlsd_pkg::ACC_LOAD: acc_q <= operand;
			dlsd_pkg::ACC_ADD:  acc_q <= acc_q + operand;
			default:            acc_q <= acc_q;
		endcase
	end

	assign acc = acc_q;

endmodule

// ===== design/dual_lane_stream_digest.sv =====
// ----------------------------------------------------------------------------
// dual_lane_stream_digest
// two-lane fnv-1a byte hash with seed combine and fmix64 finish, 128-bit out
// ----------------------------------------------------------------------------
// channel   | dir | beat contents
// s_axis    | in  | tdata: data_byte, left_a, left_b; tuser: has_byte, chain_mode; tlast
// m_axis    | out | tdata: digest_a, digest_b
//
// one shared 32x32 multiply/accumulate unit does every product and add;
// a 64-bit multiply is built on it from 32x32 partial products
// byte beat: lane a then lane b are absorbed, one after the other, before ready
// end of message: seed combine and fmix64 for lane a then lane b, chain mode a second
// pass, then the digest goes to the output register; it waits there while m_axis stalls
// reset puts both lanes and the count at their start values, no clearing pass
// ----------------------------------------------------------------------------
module dual_lane_stream_digest (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [135:0]  s_axis_tdata,   // data_byte[7:0], left_a[71:8], left_b[135:72]
	input  logic [1:0]    s_axis_tuser,   // has_byte[0], chain_mode[1]
	input  logic          s_axis_tlast,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [127:0]  m_axis_tdata    // digest_a[63:0], digest_b[127:64]
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_ABS_LD = 4'd1;
	localparam logic [3:0] ST_ABS_WB = 4'd2;
	localparam logic [3:0] ST_MUL    = 4'd3;
	localparam logic [3:0] ST_MX_PRE = 4'd4;
	localparam logic [3:0] ST_MX_K1  = 4'd5;
	localparam logic [3:0] ST_MX_K2  = 4'd6;
	localparam logic [3:0] ST_MX_END = 4'd7;
	localparam logic [3:0] ST_OUT    = 4'd8;

	logic [3:0]  state_q;
	logic [3:0]  ret_q;
	logic [1:0]  sub_q;
	logic        lane_sel_q;
	logic        pass_q;
	logic [1:0]  bsel_q;
	logic [63:0] lane1_q;
	logic [63:0] lane2_q;
	logic [63:0] cnt_q;
	logic [63:0] work_q;
	logic [63:0] da_q;
	logic [63:0] db_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        chain_q;
	logic [63:0] left_a_q;
	logic [63:0] left_b_q;
	logic [63:0] out_a_q;
	logic [63:0] out_b_q;
	logic        out_valid_q;

	logic               accept;
	logic               out_load;
	logic [63:0]        seed;
	logic [63:0]        value;
	logic [63:0]        ext;
	logic [63:0]        acc;
	logic [63:0]        lane_cur;
	logic [63:0]        h_pre;
	logic [63:0]        mix_out;
	dlsd_pkg::mac_ctl_t ctl;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

	// operands of the current mix step
	always_comb begin
		unique case ({pass_q, lane_sel_q})
			2'b00: begin
				seed  = lane1_q;
				value = cnt_q;
			end
			2'b01: begin
				seed  = lane2_q;
				value = cnt_q ^ dlsd_pkg::LEN_TWEAK;
			end
			2'b10: begin
				seed  = left_a_q;
				value = da_q;
			end
			default: begin
				seed  = left_b_q;
				value = db_q;
			end
		endcase
	end

	// seed combine addend for each pre-add step
	always_comb begin
		unique case (sub_q)
			2'd0:    ext = value;
			2'd1:    ext = dlsd_pkg::GOLDEN;
			2'd2:    ext = {seed[57:0], 6'd0};
			default: ext = {2'd0, seed[63:2]};
		endcase
	end

	assign lane_cur = lane_sel_q ? lane2_q : lane1_q;
	assign h_pre    = seed ^ acc;
	assign mix_out  = acc ^ {33'd0, acc[63:33]};

	// shared unit control
	always_comb begin
		ctl.acc_op = dlsd_pkg::ACC_HOLD;
		ctl.src    = dlsd_pkg::SRC_EXT;
		ctl.part   = dlsd_pkg::PART_NONE;
		ctl.bsel   = bsel_q;
		if (state_q == ST_MUL) begin
			unique case (sub_q)
				2'd0: ctl.part = dlsd_pkg::PART_LL;
				2'd1: begin
					ctl.acc_op = dlsd_pkg::ACC_LOAD;
					ctl.src    = dlsd_pkg::SRC_PROD;
					ctl.part   = dlsd_pkg::PART_HL;
				end
				2'd2: begin
					ctl.acc_op = dlsd_pkg::ACC_ADD;
					ctl.src    = dlsd_pkg::SRC_PROD_HI;
					ctl.part   = dlsd_pkg::PART_LH;
				end
				default: begin
					ctl.acc_op = dlsd_pkg::ACC_ADD;
					ctl.src    = dlsd_pkg::SRC_PROD_HI;
				end
			endcase
		end else if (state_q == ST_MX_PRE) begin
			ctl.acc_op = (sub_q == 2'd0) ? dlsd_pkg::ACC_LOAD : dlsd_pkg::ACC_ADD;
		end
	end

	dlsd_mac u_mac (
		.clk   (clk),
		.ctl   (ctl),
		.mul_a (work_q),
		.ext   (ext),
		.acc   (acc)
	);

	// sequencer and hash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ret_q      <= ST_IDLE;
			sub_q      <= 2'd0;
			lane_sel_q <= 1'b0;
			pass_q     <= 1'b0;
			bsel_q     <= dlsd_pkg::BSEL_PRIME;
			lane1_q    <= dlsd_pkg::OFFSET_ONE;
			lane2_q    <= dlsd_pkg::OFFSET_TWO;
			cnt_q      <= 64'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					lane_sel_q <= 1'b0;
					pass_q     <= 1'b0;
					sub_q      <= 2'd0;
					if (accept) begin
						if (s_axis_tuser[0]) begin
							state_q <= ST_ABS_LD;
						end else if (s_axis_tlast) begin
							state_q <= ST_MX_PRE;
						end
					end
				end
				ST_ABS_LD: begin
					bsel_q  <= dlsd_pkg::BSEL_PRIME;
					ret_q   <= ST_ABS_WB;
					sub_q   <= 2'd0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd3) begin
						state_q <= ret_q;
					end
				end
				ST_ABS_WB: begin
					if (!lane_sel_q) begin
						lane1_q    <= acc;
						lane_sel_q <= 1'b1;
						state_q    <= ST_ABS_LD;
					end else begin
						lane2_q    <= {acc[56:0], acc[63:57]};
						cnt_q      <= cnt_q + 64'd1;
						lane_sel_q <= 1'b0;
						pass_q     <= 1'b0;
						sub_q      <= 2'd0;
						state_q    <= last_q ? ST_MX_PRE : ST_IDLE;
					end
				end
				ST_MX_PRE: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd3) begin
						state_q <= ST_MX_K1;
					end
				end
				ST_MX_K1: begin
					bsel_q  <= dlsd_pkg::BSEL_K1;
					ret_q   <= ST_MX_K2;
					sub_q   <= 2'd0;
					state_q <= ST_MUL;
				end
				ST_MX_K2: begin
					bsel_q  <= dlsd_pkg::BSEL_K2;
					ret_q   <= ST_MX_END;
					sub_q   <= 2'd0;
					state_q <= ST_MUL;
				end
				ST_MX_END: begin
					sub_q <= 2'd0;
					if (!lane_sel_q) begin
						lane_sel_q <= 1'b1;
						state_q    <= ST_MX_PRE;
					end else begin
						lane_sel_q <= 1'b0;
						if (!pass_q && chain_q) begin
							pass_q  <= 1'b1;
							state_q <= ST_MX_PRE;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						lane1_q <= dlsd_pkg::OFFSET_ONE;
						lane2_q <= dlsd_pkg::OFFSET_TWO;
						cnt_q   <= 64'd0;
						pass_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item capture and working values
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q   <= s_axis_tdata[7:0];
			left_a_q <= s_axis_tdata[71:8];
			left_b_q <= s_axis_tdata[135:72];
			last_q   <= s_axis_tlast;
			chain_q  <= s_axis_tuser[1];
		end
		if (state_q == ST_ABS_LD) begin
			work_q <= lane_cur ^ {56'd0, byte_q};
		end else if (state_q == ST_MX_K1) begin
			work_q <= h_pre ^ {33'd0, h_pre[63:33]};
		end else if (state_q == ST_MX_K2) begin
			work_q <= mix_out;
		end
		if (state_q == ST_MX_END) begin
			if (lane_sel_q) begin
				db_q <= mix_out;
			end else begin
				da_q <= mix_out;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_a_q <= da_q;
			out_b_q <= db_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_b_q, out_a_q};

endmodule

// ===== design/dlsd_checker.sv =====
// ----------------------------------------------------------------------------
// dlsd_checker
// port-level timing checks for the dual lane stream digest
// ----------------------------------------------------------------------------
module dlsd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [1:0]  s_axis_tuser,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready
);

	// a pending digest beat stays until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("digest beat dropped while stalled");

	// a beat with work makes the input busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] || s_axis_tlast)
		|=> !s_axis_tready)
		else $error("input ready right after a working beat");

	// a plain byte beat keeps the input busy until both lanes are absorbed, then ready returns
	a_byte_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && !s_axis_tlast
		|-> ##12 !s_axis_tready ##1 s_axis_tready)
		else $error("byte beat latency off");

	// a new digest comes only out of the finish sequence
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("digest appeared while idle");

endmodule

bind dual_lane_stream_digest dlsd_checker u_dlsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the dual lane stream digest
// ----------------------------------------------------------------------------
// Message bytes go in on the slave stream and 128-bit digests come back on the
// master stream. A queue of pending beats feeds a clocked driver. Every
// accepted beat runs through a local two-lane hash model that queues the
// digest it expects. A clocked monitor compares each digest beat, field by
// field, with the oldest entry of that queue.
// Stimulus has two parts. A short directed part covers empty messages, chain
// mode, the extreme bytes and left digests, and the beats the block ignores.
// A random part follows, made of messages of random length with noise mixed
// in. Back-pressure runs in three stages: first the receiver stalls often,
// then the sender idles often, then neither side holds back.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// hash constants
	localparam logic [63:0] FNV_BASIS   = 64'hCBF29CE484222325;
	localparam logic [63:0] LANE2_BASIS = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] FNV_MULT    = 64'h00000100000001B3;
	localparam logic [63:0] PHI64       = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] AVAL_K1     = 64'hFF51AFD7ED558CCD;
	localparam logic [63:0] AVAL_K2     = 64'hC4CEB9FE1A85EC53;
	localparam logic [63:0] LEN_SALT    = 64'h00000005DEECE66D;

	localparam int TARGET_BEATS = 1950;
	localparam int STALL_LIMIT  = 3000;
	localparam int TAIL_CYCLES  = 80;

	// back-pressure stages
	typedef enum logic [1:0] {
		PH_RX_SLOW,
		PH_TX_SLOW,
		PH_FULL_RATE
	} bp_phase_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        has_byte;
		logic        last;
		logic        chain_mode;
		logic [63:0] left_a;
		logic [63:0] left_b;
		bp_phase_t   phase;
		logic        drain;
	} stim_beat_t;

	typedef struct packed {
		logic [63:0] digest_a;
		logic [63:0] digest_b;
		int          msg_idx;
	} digest_exp_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [135:0]  s_axis_tdata = '0;   // data_byte[7:0], left_a[71:8], left_b[135:72]
	logic [1:0]    s_axis_tuser = '0;   // has_byte[0], chain_mode[1]
	logic          s_axis_tlast = 1'b0;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [127:0]  m_axis_tdata;        // digest_a[63:0], digest_b[127:64]

	stim_beat_t    beat_q[$];
	digest_exp_t   digest_q[$];
	stim_beat_t    live_beat;
	bp_phase_t     fill_phase = PH_RX_SLOW;
	bp_phase_t     run_phase = PH_RX_SLOW;
	logic          drain_req = 1'b0;

	// hash state of the local model
	logic [63:0]   ln_one = FNV_BASIS;
	logic [63:0]   ln_two = LANE2_BASIS;
	logic [63:0]   msg_len = '0;

	int            n_live = 0;
	int            n_errors = 0;
	int            n_bytes = 0;
	int            n_msgs = 0;
	int            n_chained = 0;
	int            n_empty = 0;
	int            n_digests = 0;
	int            quiet_cycles = 0;

	dual_lane_stream_digest i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// seed combine followed by the fmix64 avalanche
	function automatic logic [63:0] seed_fmix(input logic [63:0] seed, input logic [63:0] val);
		logic [63:0] h;
		h = seed ^ (val + PHI64 + (seed << 6) + (seed >> 2));
		h = h ^ (h >> 33);
		h = h * AVAL_K1;
		h = h ^ (h >> 33);
		h = h * AVAL_K2;
		h = h ^ (h >> 33);
		return h;
	endfunction

	// fold one accepted beat into the lanes, queue the digest on last
	task automatic hash_beat(input stim_beat_t b);
		digest_exp_t d;
		logic [63:0] t;
		if (b.has_byte) begin
			ln_one = (ln_one ^ {56'd0, b.data_byte}) * FNV_MULT;
			t = (ln_two ^ {56'd0, b.data_byte}) * FNV_MULT;
			ln_two = {t[56:0], t[63:57]};
			msg_len = msg_len + 64'd1;
			n_bytes++;
		end
		if (b.last) begin
			d.digest_a = seed_fmix(ln_one, msg_len);
			d.digest_b = seed_fmix(ln_two, msg_len ^ LEN_SALT);
			if (b.chain_mode) begin
				d.digest_a = seed_fmix(b.left_a, d.digest_a);
				d.digest_b = seed_fmix(b.left_b, d.digest_b);
				n_chained++;
			end
			if (msg_len == 64'd0)
				n_empty++;
			d.msg_idx = n_msgs;
			digest_q.push_back(d);
			n_msgs++;
			ln_one = FNV_BASIS;
			ln_two = LANE2_BASIS;
			msg_len = '0;
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH %s", $realtime, what);
		n_errors++;
	endtask

	task automatic queue_beat(input logic [7:0] d, input logic has, input logic fin,
			input logic chn, input logic [63:0] la, input logic [63:0] lb);
		stim_beat_t b;
		b.data_byte  = d;
		b.has_byte   = has;
		b.last       = fin;
		b.chain_mode = chn;
		b.left_a     = la;
		b.left_b     = lb;
		b.phase      = fill_phase;
		b.drain      = drain_req;
		drain_req    = 1'b0;
		beat_q.push_back(b);
		n_live++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int tx_idle_pct(input bp_phase_t p);
		case (p)
			PH_RX_SLOW: return 12;
			PH_TX_SLOW: return 47;
			default:    return 0;
		endcase
	endfunction

	function automatic int rx_idle_pct(input bp_phase_t p);
		case (p)
			PH_RX_SLOW: return 47;
			PH_TX_SLOW: return 12;
			default:    return 0;
		endcase
	endfunction

	// slave side driver: predict on accept, then present the next pending beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			s_axis_tlast  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				hash_beat(live_beat);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (beat_q.size() > 0 && !(beat_q[0].drain && digest_q.size() > 0) &&
						$urandom_range(99) >= tx_idle_pct(beat_q[0].phase)) begin
					live_beat = beat_q.pop_front();
					run_phase = live_beat.phase;
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {live_beat.left_b, live_beat.left_a, live_beat.data_byte};
					s_axis_tuser  <= {live_beat.chain_mode, live_beat.has_byte};
					s_axis_tlast  <= live_beat.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// master side monitor: check each digest beat against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				digest_exp_t e;
				n_digests++;
				if (digest_q.size() == 0) begin
					report_mismatch($sformatf("digest with none expected: %h", m_axis_tdata));
				end else begin
					e = digest_q.pop_front();
					if (m_axis_tdata[63:0] !== e.digest_a)
						report_mismatch($sformatf("msg %0d digest_a exp %h got %h",
							e.msg_idx, e.digest_a, m_axis_tdata[63:0]));
					if (m_axis_tdata[127:64] !== e.digest_b)
						report_mismatch($sformatf("msg %0d digest_b exp %h got %h",
							e.msg_idx, e.digest_b, m_axis_tdata[127:64]));
				end
			end
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct(run_phase));
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d digests outstanding",
				quiet_cycles, digest_q.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int len;
		logic merge;
		logic [63:0] ones;
		ones = '1;

		// directed: empty messages, plain and chained with extreme left digests
		queue_beat(8'h00, 1'b0, 1'b1, 1'b0, rand64(), rand64());
		queue_beat(8'h00, 1'b0, 1'b1, 1'b1, 64'd0, 64'd0);
		queue_beat(8'h00, 1'b0, 1'b1, 1'b1, ones, ones);
		// byte together with last, extreme bytes
		queue_beat(8'h00, 1'b1, 1'b1, 1'b0, ones, ones);
		queue_beat(8'hFF, 1'b1, 1'b1, 1'b1, ones, 64'd0);
		queue_beat(8'hFF, 1'b1, 1'b1, 1'b1, 64'd0, ones);
		// idle beats and chain fields while last is low are ignored
		queue_beat(8'hC3, 1'b0, 1'b0, 1'b1, rand64(), rand64());
		queue_beat(8'h5A, 1'b1, 1'b0, 1'b1, ones, ones);
		queue_beat(8'h3C, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0);
		queue_beat(8'hA5, 1'b1, 1'b0, 1'b0, rand64(), rand64());
		queue_beat(8'h00, 1'b0, 1'b1, 1'b1, rand64(), rand64());
		// multi-byte message closed by a byte beat, sender waits for all digests first
		drain_req = 1'b1;
		queue_beat(8'h01, 1'b1, 1'b0, 1'b0, rand64(), rand64());
		queue_beat(8'h80, 1'b1, 1'b0, 1'b1, rand64(), rand64());
		queue_beat(8'h7F, 1'b0, 1'b0, 1'b1, rand64(), rand64());
		queue_beat(8'hFE, 1'b1, 1'b1, 1'b0, rand64(), rand64());
		// end-only right after a message closed, then a byte-less chained finish
		queue_beat(8'h11, 1'b0, 1'b1, 1'b0, rand64(), rand64());
		queue_beat(8'h00, 1'b1, 1'b0, 1'b0, rand64(), rand64());
		queue_beat(8'hFF, 1'b1, 1'b0, 1'b0, rand64(), rand64());
		queue_beat(8'h00, 1'b0, 1'b1, 1'b1, rand64(), rand64());

		// random messages with noise beats mixed in
		drain_req = 1'b1;
		while (n_live < TARGET_BEATS) begin
			if (n_live >= (2 * TARGET_BEATS) / 3)
				fill_phase = PH_FULL_RATE;
			else if (n_live >= TARGET_BEATS / 3)
				fill_phase = PH_TX_SLOW;
			if ($urandom_range(39) == 0)
				drain_req = 1'b1;
			len = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
			merge = (len > 0) && $urandom_range(1);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(9) == 0)
					queue_beat(8'($urandom_range(255)), 1'b0, 1'b0, 1'($urandom_range(1)),
						rand64(), rand64());
				queue_beat(8'($urandom_range(255)), 1'b1, merge && (k == len - 1),
					1'($urandom_range(1)), rand64(), rand64());
			end
			if (!merge)
				queue_beat(8'($urandom_range(255)), 1'b0, 1'b1, 1'($urandom_range(1)),
					rand64(), rand64());
		end

		// hold reset, then release
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the stream to drain, then for the last digests
		while (beat_q.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		while (digest_q.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d message bytes in %0d messages (%0d empty, %0d chained)",
			n_bytes, n_msgs, n_empty, n_chained);
		$display("checked %0d digest beats under three back-pressure stages, %0d mismatches",
			n_digests, n_errors);
		if (n_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
